>>> sv/rfls_pkg.sv
// Shared types, codes and reset values for the radio link supervisor.
package rfls_pkg;

	typedef enum logic [1:0] {
		ST_CONFIGURE = 2'd0,
		ST_RECEIVING = 2'd1,
		ST_RECEIVED  = 2'd2,
		ST_TIMEOUT   = 2'd3
	} loop_state_t;

	typedef enum logic [1:0] {
		OP_POLL    = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	localparam logic [2:0] REG_TIMEOUT_POLLS   = 3'd0;
	localparam logic [2:0] REG_ERROR_TOLERANCE = 3'd1;
	localparam logic [2:0] REG_CHANNEL_FIRST   = 3'd2;
	localparam logic [2:0] REG_CHANNEL_SECOND  = 3'd3;
	localparam logic [2:0] REG_CHANNEL_THIRD   = 3'd4;

	localparam logic [31:0] TIMEOUT_POLLS_RST   = 32'd1000;
	localparam logic [7:0]  ERROR_TOLERANCE_RST = 8'd5;
	localparam logic [6:0]  CHANNEL_FIRST_RST   = 7'd117;
	localparam logic [6:0]  CHANNEL_SECOND_RST  = 7'd120;
	localparam logic [6:0]  CHANNEL_THIRD_RST   = 7'd122;

	localparam logic [2:0] NO_MODE     = 3'd4;
	localparam logic [1:0] LAST_CHAN   = 2'd2;
	localparam logic [7:0] COUNT_MAX   = 8'd255;
	localparam logic [1:0] COMM_RESET  = 2'd3;

	localparam logic [1:0] STATUS_RECEIVING = 2'd0;
	localparam logic [1:0] STATUS_RECEIVED  = 2'd1;
	localparam logic [1:0] STATUS_TIMED_OUT = 2'd2;

	typedef struct packed {
		logic [31:0] timeout_polls;
		logic [7:0]  error_tolerance;
		logic [6:0]  channel_first;
		logic [6:0]  channel_second;
		logic [6:0]  channel_third;
	} cfg_t;

	typedef struct packed {
		logic       list_full;
		logic [2:0] msg_code;
		logic       msg_valid;
		opcode_t    opcode;
	} item_t;

	typedef struct packed {
		logic [7:0]  timeout_count;
		logic [6:0]  hop_channel;
		logic        hop_request;
		logic [2:0]  mode_code;
		logic [1:0]  link_status;
		logic [1:0]  read_status;
		loop_state_t rx_state;
	} result_t;

endpackage

>>> sv/rf_link_supervisor_fsm.sv
// Top level of the radio link supervisor: input register, state update and result register.
//
// Usage: each item on the s_ channel is one command. s_tuser carries the opcode
// (poll step, maintenance clear, restart); s_tdata carries the message fields
// of a poll. Every item yields exactly one result item on the m_ channel with
// the loop state, status codes, latched mode, hop request and timeout count
// as they stand after that command.
// Order: an accepted item is loaded into the input register, and its result is
// written to the result register when the item advances, which a stall on
// m_tready can hold back.
// Throughput: one item per clock cycle while results are taken; the supervisor
// state is updated as the item moves from the input register to the result
// register, with one 32-bit compare and increment of the receive timer as the
// longest path.
// Reset: arst_n clears both registers, returns the loop to configure with all counters
// and flags cleared, no mode latched, and the configuration registers at their defaults.
// The user must write the configuration port only while idle; the block does not enforce it.
// Stall: while m_tready is low the result is held; one more item is taken into
// the input register, and then s_tready drops until the result is taken.
module rf_link_supervisor_fsm
	import rfls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata fields from bit 0: msg_valid, msg_code[2:0], list_full, zero fill.
	input  logic [7:0]  s_tdata,
	// s_tuser fields from bit 0: opcode[1:0].
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata fields from bit 0: rx_state[1:0], read_status[1:0], link_status[1:0],
	// mode_code[2:0], hop_request, hop_channel[6:0], timeout_count[7:0], zero fill.
	output logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t        cfg;
	item_t       item_s1;
	logic        valid_s1;
	logic        advance;
	result_t     res_q;
	logic        res_valid_q;
	result_t     res_d;

	loop_state_t state_q, state_d;
	logic [31:0] wait_q, wait_d;
	logic [7:0]  tcount_q, tcount_d, tcount_inc;
	logic [1:0]  chan_idx_q, chan_idx_d;
	logic        hopping_q, hopping_d;
	logic        fixing_q, fixing_d;
	logic        error_q, error_d;
	logic        reset_q, reset_d;
	logic [2:0]  mode_q, mode_d;
	logic        hop;
	logic [6:0]  hop_chan;
	logic        poll;
	logic        timed_out;
	logic        good_msg;

	rfls_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.opcode    <= opcode_t'(s_tuser);
			item_s1.msg_valid <= s_tdata[0];
			item_s1.msg_code  <= s_tdata[3:1];
			item_s1.list_full <= s_tdata[4];
		end
	end

	assign poll       = (item_s1.opcode == OP_POLL);
	assign timed_out  = (wait_q >= cfg.timeout_polls);
	assign good_msg   = item_s1.msg_valid && !item_s1.list_full && (item_s1.msg_code < NO_MODE);
	assign tcount_inc = (tcount_q < COUNT_MAX) ? tcount_q + 8'd1 : tcount_q;
	assign hop        = poll && (state_q == ST_TIMEOUT) && (tcount_inc >= cfg.error_tolerance);

	always_comb begin
		state_d = state_q;
		case (item_s1.opcode)
			OP_POLL: begin
				case (state_q)
					ST_CONFIGURE: state_d = ST_RECEIVING;
					ST_RECEIVING: begin
						if (timed_out) begin
							state_d = ST_TIMEOUT;
						end else if (good_msg) begin
							state_d = ST_RECEIVED;
						end
					end
					ST_RECEIVED:  state_d = ST_CONFIGURE;
					ST_TIMEOUT:   state_d = ST_CONFIGURE;
					default:      state_d = ST_CONFIGURE;
				endcase
			end
			OP_RESTART: state_d = ST_CONFIGURE;
			default:    state_d = state_q;
		endcase
	end

	always_comb begin
		case (chan_idx_q)
			2'd0:    hop_chan = cfg.channel_first;
			2'd1:    hop_chan = cfg.channel_second;
			default: hop_chan = cfg.channel_third;
		endcase
	end

	always_comb begin
		wait_d     = wait_q;
		tcount_d   = tcount_q;
		chan_idx_d = chan_idx_q;
		hopping_d  = hopping_q;
		fixing_d   = fixing_q;
		error_d    = error_q;
		reset_d    = reset_q;
		mode_d     = mode_q;
		case (item_s1.opcode)
			OP_POLL: begin
				case (state_q)
					ST_CONFIGURE: wait_d = 32'd0;
					ST_RECEIVING: begin
						if (!timed_out) begin
							wait_d = wait_q + 32'd1;
							if (item_s1.msg_valid && item_s1.list_full) begin
								reset_d = 1'b1;
							end else if (good_msg) begin
								mode_d   = item_s1.msg_code;
								tcount_d = 8'd0;
							end
						end
					end
					ST_RECEIVED: begin
						if (!reset_q) begin
							hopping_d = 1'b0;
							fixing_d  = 1'b0;
							error_d   = 1'b0;
						end
					end
					default: begin
						tcount_d = tcount_inc;
						if (hop) begin
							tcount_d  = 8'd0;
							hopping_d = 1'b1;
							if (chan_idx_q >= LAST_CHAN) begin
								chan_idx_d = 2'd0;
								fixing_d   = 1'b1;
								error_d    = error_q || fixing_q;
							end else begin
								chan_idx_d = chan_idx_q + 2'd1;
							end
						end
					end
				endcase
			end
			OP_CLEAR: begin
				hopping_d = 1'b0;
				fixing_d  = 1'b0;
				error_d   = 1'b0;
				reset_d   = 1'b0;
			end
			OP_RESTART: wait_d = 32'd0;
			default: ;
		endcase
	end

	always_comb begin
		res_d.rx_state = state_d;
		case (state_d)
			ST_TIMEOUT:  res_d.read_status = STATUS_TIMED_OUT;
			ST_RECEIVED: res_d.read_status = STATUS_RECEIVED;
			default:     res_d.read_status = STATUS_RECEIVING;
		endcase
		if (reset_d) begin
			res_d.link_status = COMM_RESET;
		end else begin
			res_d.link_status = {1'b0, hopping_d} + {1'b0, fixing_d} + {1'b0, error_d};
		end
		res_d.mode_code     = mode_d;
		res_d.hop_request   = hop;
		res_d.hop_channel   = hop ? hop_chan : 7'd0;
		res_d.timeout_count = tcount_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CONFIGURE;
			wait_q     <= 32'd0;
			tcount_q   <= 8'd0;
			chan_idx_q <= 2'd0;
			hopping_q  <= 1'b0;
			fixing_q   <= 1'b0;
			error_q    <= 1'b0;
			reset_q    <= 1'b0;
			mode_q     <= NO_MODE;
		end else if (advance) begin
			state_q    <= state_d;
			wait_q     <= wait_d;
			tcount_q   <= tcount_d;
			chan_idx_q <= chan_idx_d;
			hopping_q  <= hopping_d;
			fixing_q   <= fixing_d;
			error_q    <= error_d;
			reset_q    <= reset_d;
			mode_q     <= mode_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {7'd0, res_q};

	assert property (@(posedge clk) disable iff (!arst_n) chan_idx_q != 2'd3)
		else $error("Channel index left the three-channel hop sequence.");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.hop_request |-> res_q.timeout_count == 8'd0
			&& res_q.rx_state == ST_CONFIGURE)
		else $error("A hop result does not show a cleared count in configure.");

	assert property (@(posedge clk) disable iff (!arst_n)
		error_q && !$past(error_q) && $past(advance) |-> fixing_q && $past(fixing_q))
		else $error("Error flag set without fixing already set.");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !m_tready |=> valid_s1 && $stable(state_q))
		else $error("Supervisor state moved while the result was stalled.");

endmodule

>>> sv/rfls_cfg.sv
// APB configuration registers of the radio link supervisor.
module rfls_cfg
	import rfls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_polls   <= TIMEOUT_POLLS_RST;
			cfg_q.error_tolerance <= ERROR_TOLERANCE_RST;
			cfg_q.channel_first   <= CHANNEL_FIRST_RST;
			cfg_q.channel_second  <= CHANNEL_SECOND_RST;
			cfg_q.channel_third   <= CHANNEL_THIRD_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TIMEOUT_POLLS:   cfg_q.timeout_polls   <= pwdata;
				REG_ERROR_TOLERANCE: cfg_q.error_tolerance <= pwdata[7:0];
				REG_CHANNEL_FIRST:   cfg_q.channel_first   <= pwdata[6:0];
				REG_CHANNEL_SECOND:  cfg_q.channel_second  <= pwdata[6:0];
				REG_CHANNEL_THIRD:   cfg_q.channel_third   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TIMEOUT_POLLS:   prdata = cfg_q.timeout_polls;
			REG_ERROR_TOLERANCE: prdata = {24'd0, cfg_q.error_tolerance};
			REG_CHANNEL_FIRST:   prdata = {25'd0, cfg_q.channel_first};
			REG_CHANNEL_SECOND:  prdata = {25'd0, cfg_q.channel_second};
			REG_CHANNEL_THIRD:   prdata = {25'd0, cfg_q.channel_third};
			default:             prdata = 32'd0;
		endcase
	end

endmodule
